[hw/rtl/qpv_pkg.sv]
`default_nettype none
package qpv_pkg;
    localparam int CountWidth = 32;
    localparam int MpcWidth = 24;
    localparam int FiltWidth = 10;
    localparam int DtWidth = 24;
    localparam int OutWidth = 56;
    // product of 32-bit magnitude and mpc*1e6 (44 bits)
    localparam int ProdWidth = 76;
    localparam int MulWidth = 44;
    localparam int QueueDepth = 4;
    localparam logic [19:0] Micro = 20'd1000000;
    localparam logic [FiltWidth-1:0] FiltReset = 10'd250;
    localparam logic [FiltWidth-1:0] HoldMax = 10'd1023;

    localparam logic [2:0] CmdNone = 3'd0;
    localparam logic [2:0] CmdVelocity = 3'd1;
    localparam logic [2:0] CmdDistStart = 3'd2;
    localparam logic [2:0] CmdDistTake = 3'd3;
    localparam logic [2:0] CmdReset = 3'd4;

    localparam logic [0:0] RegMpc = 1'b0;
    localparam logic [0:0] RegFilter = 1'b1;

    typedef struct packed {
        logic [CountWidth-1:0] position;
        logic                  dist_neg;
        logic [CountWidth-1:0] dist_mag;
        logic                  vel_en;
        logic                  vel_neg;
        logic [CountWidth-1:0] vel_mag;
        logic [DtWidth-1:0]    dt_us;
        logic                  glitch;
    } job_t;

    typedef struct packed {
        logic [CountWidth-1:0] position;
        logic [OutWidth-1:0]   velocity;
        logic [OutWidth-1:0]   distance;
        logic                  glitch;
    } result_t;
endpackage
`default_nettype wire

[hw/rtl/qpv_if.sv]
`default_nettype none
interface qpv_in_if;
    logic       valid;
    logic       ready;
    logic       pin_a;
    logic       pin_b;
    logic [2:0] cmd;
    logic [23:0] dt_us;
    modport source (output valid, pin_a, pin_b, cmd, dt_us, input ready);
    modport sink (input valid, pin_a, pin_b, cmd, dt_us, output ready);
endinterface

interface qpv_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] position;
    logic [55:0] velocity;
    logic [55:0] distance;
    logic        glitch;
    modport source (output valid, position, velocity, distance, glitch, input ready);
    modport sink (input valid, position, velocity, distance, glitch, output ready);
endinterface

interface qpv_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/quadrature_position_velocity.sv]
`default_nettype none
// channel  dir  payload
// in_ch    in   pin_a, pin_b, cmd, dt_us
// out_ch   out  position, velocity, distance, glitch
// cfg      in   index, data
// The front counts one sample per cycle while the queue has room; the back
// takes a new job only after the last result is taken (76-bit restoring
// divider for velocity). A 4-entry queue separates them; the front stalls only
// when it is full. Queue and result data are not reset; the config port is always ready.
module quadrature_position_velocity (
    input  wire logic clk,
    input  wire logic rst_n,
    qpv_in_if.sink    in_ch,
    qpv_out_if.source out_ch,
    qpv_cfg_if.sink   cfg
);
    logic [qpv_pkg::MpcWidth-1:0] mpc_reg;
    logic [qpv_pkg::FiltWidth-1:0] filt_reg;
    logic push, full, pop, empty;
    qpv_pkg::job_t job, qjob;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpc_reg <= '0;
            filt_reg <= qpv_pkg::FiltReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                qpv_pkg::RegMpc: mpc_reg <= cfg.data;
                qpv_pkg::RegFilter: filt_reg <= cfg.data[qpv_pkg::FiltWidth-1:0];
                default: ;
            endcase
        end
    end

    qpv_front u_front (.clk, .rst_n, .in_ch, .filter_length(filt_reg),
        .q_full(full), .push, .job);
    qpv_queue u_queue (.clk, .rst_n, .push, .push_data(job), .full, .pop,
        .empty, .pop_data(qjob));
    qpv_back u_back (.clk, .rst_n, .q_empty(empty), .q_data(qjob), .pop,
        .meters_per_count(mpc_reg), .out_ch);
endmodule
`default_nettype wire

[hw/rtl/qpv_front.sv]
`default_nettype none
module qpv_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    qpv_in_if.sink                              in_ch,
    input  wire logic [qpv_pkg::FiltWidth-1:0]  filter_length,
    input  wire logic                           q_full,
    output logic                                push,
    output qpv_pkg::job_t                       job
);
    logic level_a_reg, level_b_reg;
    logic [qpv_pkg::FiltWidth-1:0] hold_a_reg, hold_b_reg, hold_a_next, hold_b_next;
    logic [qpv_pkg::CountWidth-1:0] tick_reg, vref_reg, dref_reg, tick_cnt, tick_next;
    logic [qpv_pkg::CountWidth-1:0] dd, vd;
    logic na, nb, ca, cb;

    function automatic logic [qpv_pkg::FiltWidth-1:0] hold_inc(
        input logic [qpv_pkg::FiltWidth-1:0] c);
        hold_inc = (c < qpv_pkg::HoldMax) ? c + 1'b1 : c;
    endfunction

    assign in_ch.ready = !q_full;
    assign push = in_ch.valid && !q_full;

    always_comb
    begin
        na = level_a_reg;
        nb = level_b_reg;
        hold_a_next = '0;
        hold_b_next = '0;
        if (in_ch.pin_a != level_a_reg)
        begin
            hold_a_next = hold_inc(hold_a_reg);
            if (hold_a_next >= filter_length)
            begin
                hold_a_next = '0;
                na = in_ch.pin_a;
            end
        end
        if (in_ch.pin_b != level_b_reg)
        begin
            hold_b_next = hold_inc(hold_b_reg);
            if (hold_b_next >= filter_length)
            begin
                hold_b_next = '0;
                nb = in_ch.pin_b;
            end
        end
        ca = na != level_a_reg;
        cb = nb != level_b_reg;
        tick_cnt = tick_reg;
        if (ca && !cb)
            tick_cnt = (na == level_b_reg) ? tick_reg + 1'b1 : tick_reg - 1'b1;
        else if (cb && !ca)
            tick_cnt = (nb != level_a_reg) ? tick_reg + 1'b1 : tick_reg - 1'b1;
        dd = tick_cnt - dref_reg;
        vd = tick_cnt - vref_reg;
        tick_next = (in_ch.cmd == qpv_pkg::CmdReset) ? '0 : tick_cnt;
        job.position = tick_next;
        job.dist_neg = dd[qpv_pkg::CountWidth-1];
        job.dist_mag = dd[qpv_pkg::CountWidth-1] ? -dd : dd;
        job.vel_neg = vd[qpv_pkg::CountWidth-1];
        job.vel_mag = vd[qpv_pkg::CountWidth-1] ? -vd : vd;
        job.vel_en = (in_ch.cmd == qpv_pkg::CmdVelocity) && (in_ch.dt_us != '0);
        job.dt_us = in_ch.dt_us;
        job.glitch = ca && cb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg <= 1'b0;
            level_b_reg <= 1'b0;
            hold_a_reg <= '0;
            hold_b_reg <= '0;
            tick_reg <= '0;
            vref_reg <= '0;
            dref_reg <= '0;
        end
        else if (push)
        begin
            level_a_reg <= na;
            level_b_reg <= nb;
            hold_a_reg <= hold_a_next;
            hold_b_reg <= hold_b_next;
            tick_reg <= tick_next;
            case (in_ch.cmd)
                qpv_pkg::CmdVelocity: vref_reg <= tick_cnt;
                qpv_pkg::CmdDistStart, qpv_pkg::CmdDistTake: dref_reg <= tick_cnt;
                qpv_pkg::CmdReset:
                begin
                    vref_reg <= '0;
                    dref_reg <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/qpv_queue.sv]
`default_nettype none
module qpv_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  qpv_pkg::job_t      push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output qpv_pkg::job_t      pop_data
);
    localparam int Aw = $clog2(qpv_pkg::QueueDepth);
    qpv_pkg::job_t mem_reg [qpv_pkg::QueueDepth];
    logic [Aw-1:0] wr_reg, rd_reg;
    logic [Aw:0] cnt_reg;

    assign full = cnt_reg == Aw'(0) + (Aw+1)'(qpv_pkg::QueueDepth);
    assign empty = cnt_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (Aw+1)'(push) - (Aw+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/qpv_back.sv]
`default_nettype none
module qpv_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  qpv_pkg::job_t                      q_data,
    output logic                               pop,
    input  wire logic [qpv_pkg::MpcWidth-1:0]  meters_per_count,
    qpv_out_if.source                          out_ch
);
    localparam int Pw = qpv_pkg::ProdWidth;
    localparam int Mw = qpv_pkg::MulWidth;
    localparam int Cw = qpv_pkg::CountWidth;
    localparam int Ow = qpv_pkg::OutWidth;
    localparam int Dw = qpv_pkg::DtWidth;
    localparam logic [Ow:0] PosMax = {2'b00, {(Ow-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE, S_MPC, S_MUL_LO, S_MUL_HI, S_DIV, S_SAT, S_OUT
    } state_t;
    state_t state_reg;
    qpv_pkg::job_t job_reg;
    logic [Mw-1:0] mul_reg;
    logic [Pw-1:0] prod_reg, quo_reg;
    logic [Dw:0] rem_reg;
    logic [6:0] bit_reg;
    logic [Cw+qpv_pkg::MpcWidth-1:0] dprod_reg;
    logic [Cw-1:0] pos_reg;
    logic [Ow-1:0] vel_reg, dist_reg;
    logic glitch_reg;
    logic [Dw+1:0] trial;
    logic [Dw:0] rem_sh;
    logic [Mw-1:0] mpc_scaled;
    logic [Cw+21:0] part_lo, part_hi;

    function automatic logic [Ow-1:0] sat(input logic [Pw-1:0] m, input logic neg);
        logic [Ow:0] lim;
        logic [Ow:0] v;
        lim = neg ? PosMax + 1'b1 : PosMax;
        v = (m > Pw'(lim)) ? lim : m[Ow:0];
        sat = neg ? Ow'(-v) : v[Ow-1:0];
    endfunction

    // mpc*1e6 fits 44 bits; the velocity product is split in two 22-bit halves
    assign mpc_scaled = meters_per_count * qpv_pkg::Micro;
    assign part_lo = job_reg.vel_mag * mul_reg[21:0];
    assign part_hi = job_reg.vel_mag * mul_reg[Mw-1:22];

    assign rem_sh = {rem_reg[Dw-1:0], quo_reg[Pw-1]};
    assign trial = {1'b0, rem_sh} - {2'b00, job_reg.dt_us};
    assign pop = (state_reg == S_IDLE) && !q_empty;
    assign out_ch.valid = state_reg == S_OUT;
    assign out_ch.position = pos_reg;
    assign out_ch.velocity = vel_reg;
    assign out_ch.distance = dist_reg;
    assign out_ch.glitch = glitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (!q_empty)
                    begin
                        job_reg <= q_data;
                        state_reg <= S_MPC;
                    end
                S_MPC:
                begin
                    mul_reg <= mpc_scaled;
                    dprod_reg <= job_reg.dist_mag * meters_per_count;
                    state_reg <= S_MUL_LO;
                end
                S_MUL_LO:
                begin
                    dist_reg <= sat(Pw'(dprod_reg), job_reg.dist_neg);
                    pos_reg <= job_reg.position;
                    glitch_reg <= job_reg.glitch;
                    prod_reg <= Pw'(part_lo);
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    quo_reg <= prod_reg + (Pw'(part_hi) << 22);
                    rem_reg <= '0;
                    bit_reg <= 7'(Pw);
                    if (job_reg.vel_en)
                        state_reg <= S_DIV;
                    else
                    begin
                        vel_reg <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (!trial[Dw+1])
                    begin
                        rem_reg <= trial[Dw:0];
                        quo_reg <= {quo_reg[Pw-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[Pw-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 7'd1)
                        state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    vel_reg <= sat(quo_reg, job_reg.vel_neg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[bench/tb_quadrature_position_velocity.sv]
`timescale 1ns / 100ps
module tb_quadrature_position_velocity;

    class qpv_scoreboard;
        logic [qpv_pkg::MpcWidth-1:0]   mpc;
        logic [qpv_pkg::FiltWidth-1:0]  filt_len;
        bit                             lvl_a, lvl_b;
        logic [qpv_pkg::FiltWidth-1:0]  hold_a, hold_b;
        logic [qpv_pkg::CountWidth-1:0] ticks, vel_ref, dist_ref;
        qpv_pkg::result_t               expected_results[$];
        int                             errors;

        function new();
            mpc = '0;
            filt_len = qpv_pkg::FiltReset;
            lvl_a = 1'b0;
            lvl_b = 1'b0;
            hold_a = '0;
            hold_b = '0;
            ticks = '0;
            vel_ref = '0;
            dist_ref = '0;
            errors = 0;
        endfunction

        function bit filter_level(bit pin, bit lvl,
                                  inout logic [qpv_pkg::FiltWidth-1:0] cnt);
            if (pin == lvl)
            begin
                cnt = '0;
                return lvl;
            end
            if (cnt < qpv_pkg::HoldMax)
                cnt = cnt + 1'b1;
            if (cnt >= filt_len)
            begin
                cnt = '0;
                return pin;
            end
            return lvl;
        endfunction

        // signed count difference scaled by mul / div, truncated, saturated to 56 bits
        function logic [qpv_pkg::OutWidth-1:0] scaled_delta(
            logic [qpv_pkg::CountWidth-1:0] a,
            logic [qpv_pkg::CountWidth-1:0] b,
            logic [63:0] mul, logic [qpv_pkg::DtWidth-1:0] div);
            logic [qpv_pkg::CountWidth-1:0] d;
            logic [127:0]                   q;
            logic [qpv_pkg::OutWidth-1:0]   lim;
            bit                             neg;
            d = a - b;
            neg = d[qpv_pkg::CountWidth-1];
            if (neg)
                d = -d;
            q = ({96'b0, d} * {64'b0, mul}) / {104'b0, div};
            lim = neg ? {1'b1, {(qpv_pkg::OutWidth-1){1'b0}}}
                      : {1'b0, {(qpv_pkg::OutWidth-1){1'b1}}};
            if (q > {72'b0, lim})
                q = {72'b0, lim};
            return neg ? -q[qpv_pkg::OutWidth-1:0] : q[qpv_pkg::OutWidth-1:0];
        endfunction

        function void write_reg(logic [0:0] idx, logic [23:0] data);
            if (idx == qpv_pkg::RegMpc)
                mpc = data;
            else
                filt_len = data[qpv_pkg::FiltWidth-1:0];
        endfunction

        function void note_sample(bit pa, bit pb, logic [2:0] cmd,
                                  logic [qpv_pkg::DtWidth-1:0] dt);
            bit               na, nb, ca, cb;
            qpv_pkg::result_t r;
            na = filter_level(pa, lvl_a, hold_a);
            nb = filter_level(pb, lvl_b, hold_b);
            ca = na != lvl_a;
            cb = nb != lvl_b;
            r.glitch = ca && cb;
            if (ca && !cb)
                ticks = (na == lvl_b) ? ticks + 1'b1 : ticks - 1'b1;
            else if (cb && !ca)
                ticks = (nb != lvl_a) ? ticks + 1'b1 : ticks - 1'b1;
            lvl_a = na;
            lvl_b = nb;
            r.distance = scaled_delta(ticks, dist_ref, {40'b0, mpc}, 24'd1);
            r.velocity = '0;
            if (cmd == qpv_pkg::CmdVelocity)
            begin
                if (dt != 0)
                    r.velocity = scaled_delta(ticks, vel_ref,
                                              64'(mpc) * 64'(qpv_pkg::Micro), dt);
                vel_ref = ticks;
            end
            else if (cmd == qpv_pkg::CmdDistStart || cmd == qpv_pkg::CmdDistTake)
                dist_ref = ticks;
            else if (cmd == qpv_pkg::CmdReset)
            begin
                ticks = '0;
                vel_ref = '0;
                dist_ref = '0;
            end
            r.position = ticks;
            expected_results.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t %s mismatch: expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(qpv_pkg::result_t act);
            qpv_pkg::result_t e;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, act);
                return;
            end
            e = expected_results.pop_front();
            compare("position", 64'(e.position), 64'(act.position));
            compare("velocity", 64'(e.velocity), 64'(act.velocity));
            compare("distance", 64'(e.distance), 64'(act.distance));
            compare("glitch", 64'(e.glitch), 64'(act.glitch));
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    int   sender_idle = 0;
    int   receiver_stall = 0;
    int   cycles = 0;
    qpv_scoreboard sb = new();

    qpv_in_if  in_ch();
    qpv_out_if out_ch();
    qpv_cfg_if cfg();

    quadrature_position_velocity dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("tb_quadrature_position_velocity failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.position, out_ch.velocity, out_ch.distance,
                             out_ch.glitch});
        out_ch.ready <= ($urandom_range(99) >= receiver_stall);
    end

    task automatic send_sample(bit pa, bit pb, logic [2:0] cmd,
                               logic [qpv_pkg::DtWidth-1:0] dt);
        while ($urandom_range(99) < sender_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pin_a <= pa;
        in_ch.pin_b <= pb;
        in_ch.cmd   <= cmd;
        in_ch.dt_us <= dt;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_sample(pa, pb, cmd, dt);
    endtask

    // stop sending, let every result drain, then allow for the divider latency
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [23:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [qpv_pkg::DtWidth-1:0] pick_dt();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel < 5)
            return qpv_pkg::DtWidth'($urandom_range(1000, 1));
        return qpv_pkg::DtWidth'($urandom());
    endfunction

    // quadrature walk: each state held long enough to pass the filter, with noise
    task automatic encoder_walk(int n);
        int   pos;
        int   dir;
        int   hold;
        logic [2:0] cmd;
        bit   a, b;
        pos = 0;
        dir = 1;
        while (n > 0)
        begin
            if ($urandom_range(99) < 15)
                dir = -dir;
            pos = (pos + dir) & 3;
            a = (pos == 1) || (pos == 2);
            b = pos >= 2;
            hold = int'(sb.filt_len) + $urandom_range(2);
            if (hold == 0)
                hold = 1;
            for (int i = 0; i < hold && n > 0; i++)
            begin
                cmd = ($urandom_range(99) < 75) ? qpv_pkg::CmdNone : 3'($urandom_range(7));
                if ($urandom_range(99) < 8)
                    send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), cmd,
                                pick_dt());
                else
                    send_sample(a, b, cmd, pick_dt());
                n--;
            end
        end
    endtask

    initial
    begin
        in_ch.valid = 0;
        in_ch.pin_a = 0;
        in_ch.pin_b = 0;
        in_ch.cmd = qpv_pkg::CmdNone;
        in_ch.dt_us = '0;
        cfg.valid = 0;
        cfg.index = qpv_pkg::RegMpc;
        cfg.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: long filter, zero scale
        send_sample(1'b1, 1'b0, qpv_pkg::CmdNone, 24'd5);
        send_sample(1'b1, 1'b1, qpv_pkg::CmdVelocity, 24'd5);
        drain();

        write_reg(qpv_pkg::RegMpc, 24'd3);
        write_reg(qpv_pkg::RegFilter, 24'd0);
        for (int c = 0; c < 8; c++)
            send_sample(c[0], c[1], 3'(c), 24'd7);
        send_sample(1'b1, 1'b1, qpv_pkg::CmdNone, 24'd0);
        // both pins change at once, zero dt
        send_sample(1'b0, 1'b0, qpv_pkg::CmdVelocity, 24'd0);
        send_sample(1'b1, 1'b0, qpv_pkg::CmdDistStart, 24'hFFFFFF);
        send_sample(1'b0, 1'b0, qpv_pkg::CmdNone, 24'd1);
        send_sample(1'b0, 1'b1, qpv_pkg::CmdNone, 24'd1);       // count rises above zero
        send_sample(1'b1, 1'b1, qpv_pkg::CmdVelocity, 24'd1);
        send_sample(1'b1, 1'b1, qpv_pkg::CmdDistTake, 24'd1);
        send_sample(1'b1, 1'b1, qpv_pkg::CmdReset, 24'd1);
        drain();

        write_reg(qpv_pkg::RegFilter, 24'd1);
        write_reg(qpv_pkg::RegMpc, 24'hFFFFFF);
        send_sample(1'b0, 1'b1, qpv_pkg::CmdNone, 24'd1);
        send_sample(1'b0, 1'b0, qpv_pkg::CmdNone, 24'd1);
        send_sample(1'b1, 1'b0, qpv_pkg::CmdVelocity, 24'd1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle = 0;
                    receiver_stall = 0;
                end
                1:
                begin
                    sender_idle = 88;
                    receiver_stall = 0;
                end
                2:
                begin
                    sender_idle = 0;
                    receiver_stall = 88;
                end
                default:
                begin
                    sender_idle = 30;
                    receiver_stall = 30;
                end
            endcase
            write_reg(qpv_pkg::RegMpc, ph == 0 ? 24'hFFFFFF : ph == 1 ? 24'd1 :
                                       ph == 2 ? 24'($urandom()) : 24'd0);
            write_reg(qpv_pkg::RegFilter, ph < 2 ? 24'(ph) : 24'($urandom_range(4, 2)));
            encoder_walk(60);
            if (ph == 1)
                drain();    // sender holds off until every result is back
            encoder_walk(55);
            drain();
        end

        // long filter, pin held against the level until it is taken
        sender_idle = 0;
        receiver_stall = 0;
        write_reg(qpv_pkg::RegFilter, 24'd200);
        write_reg(qpv_pkg::RegMpc, 24'($urandom()));
        for (int i = 0; i < 205; i++)
            send_sample(!sb.lvl_a, sb.lvl_b,
                        i == 204 ? qpv_pkg::CmdVelocity : qpv_pkg::CmdNone, 24'd3);
        drain();

        if (sb.errors == 0)
            $display("tb_quadrature_position_velocity passed");
        else
            $display("tb_quadrature_position_velocity failed");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/qpv_pkg.sv
hw/rtl/qpv_if.sv
hw/rtl/qpv_front.sv
hw/rtl/qpv_queue.sv
hw/rtl/qpv_back.sv
hw/rtl/quadrature_position_velocity.sv
bench/tb_quadrature_position_velocity.sv
